// ===== rtl/core/velocity_shape_and_slew_axis_unit_assert.svh =====
// Assertion macros for the velocity shaping and slew unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef VELOCITY_SHAPE_AND_SLEW_AXIS_UNIT_ASSERT_SVH
`define VELOCITY_SHAPE_AND_SLEW_AXIS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSS_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("velocity unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define VSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("velocity unit check failed");

`endif

// ===== rtl/core/vel_slew_pkg.sv =====
`default_nettype none

package vel_slew_pkg;

    typedef enum logic [1:0] {
        MODE_PASSTHROUGH = 2'd0,
        MODE_BOOST       = 2'd1,
        MODE_STOP        = 2'd2,
        MODE_NO_SOURCE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_DEADBAND     = 3'd0,
        CFG_GAIN         = 3'd1,
        CFG_BOOST_FLOOR  = 3'd2,
        CFG_VEL_LOW      = 3'd3,
        CFG_VEL_HIGH     = 3'd4,
        CFG_ACCEL_LIMIT  = 3'd5,
        CFG_DECEL_LIMIT  = 3'd6,
        CFG_IDLE_EPSILON = 3'd7
    } cfg_index_t;

    localparam logic signed [15:0] DEADBAND_RESET     = 16'sd0;
    localparam logic        [15:0] GAIN_RESET         = 16'd6144;
    localparam logic        [14:0] BOOST_FLOOR_RESET  = 15'd1024;
    localparam logic signed [15:0] VEL_LOW_RESET      = -16'sd614;
    localparam logic signed [15:0] VEL_HIGH_RESET     = 16'sd4915;
    localparam logic signed [15:0] ACCEL_LIMIT_RESET  = 16'sd10240;
    localparam logic signed [15:0] DECEL_LIMIT_RESET  = -16'sd16384;
    localparam logic        [14:0] IDLE_EPSILON_RESET = 15'd4;

    localparam logic [16:0] DT_ONE      = 17'h10000;
    localparam logic [32:0] BOOST_ROUND = 33'h000000800;
    localparam logic [32:0] STEP_ROUND  = 33'h000008000;
    localparam logic [19:0] NEG_LIMIT   = 20'd32768;
    localparam logic [19:0] POS_LIMIT   = 20'd32767;

    typedef struct packed {
        logic signed [15:0] command;
        mode_t              mode;
        logic               feedback_valid;
        logic signed [15:0] feedback_velocity;
        logic        [16:0] tick_dt;
    } in_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/velocity_shape_and_slew_axis_unit.sv =====
// Velocity shaping and slew limiting for one motion axis.
// Requests arrive on the in channel (valid/ready) with the raw command, the
// mode, optional fresh feedback and the tick time. Each request produces
// exactly one result on the out channel (valid/ready): the rate limited
// velocity and its publish flag.
// An accepted request is held in the input register. From there the
// deadband, boost, clamp and slew step against the previous output are
// computed in one pass and loaded into the result register once that
// register is free or is being emptied. One request is taken in every
// cycle while the receiver keeps up.
// When the receiver stalls, the result register holds and one more request
// waits in the input register; in_ready falls only when both are occupied,
// and it rises in the same cycle that out_ready frees the result register.
// The configuration channel takes a register index and data and is always
// ready; the user must write registers only while no request is in flight, as the block does not enforce it.
// Reset clears both valid flags, loads the configuration defaults and
// sets the last output velocity to zero.
`default_nettype none

module velocity_shape_and_slew_axis_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [15:0] command,
    input  wire logic        [1:0]  mode,
    input  wire logic               feedback_valid,
    input  wire logic signed [15:0] feedback_velocity,
    input  wire logic        [16:0] tick_dt,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [15:0] velocity,
    output      logic               publish,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [15:0] cfg_data
);

    logic signed [15:0] deadband_reg, deadband_next;
    logic        [15:0] gain_reg, gain_next;
    logic        [14:0] boost_floor_reg, boost_floor_next;
    logic signed [15:0] vel_low_reg, vel_low_next;
    logic signed [15:0] vel_high_reg, vel_high_next;
    logic signed [15:0] accel_limit_reg, accel_limit_next;
    logic signed [15:0] decel_limit_reg, decel_limit_next;
    logic        [14:0] idle_epsilon_reg, idle_epsilon_next;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;

    vel_slew_pkg::in_item_t s1_reg, s1_next;

    logic signed [15:0] last_output_reg, last_output_next;
    logic signed [15:0] out_velocity_reg, out_velocity_next;
    logic               out_publish_reg, out_publish_next;

    logic s1_go;

    // Shaping signals
    logic signed [16:0] cmd_ext, db_ext;
    logic        [16:0] cmd_mag, db_mag, filt_mag;
    logic               in_deadband;
    logic signed [15:0] filtered;
    logic               boost_neg;
    logic        [32:0] boost_full, boost_sum;
    logic        [19:0] boost_round, boost_lifted;
    logic signed [15:0] boost_value, pre_clamp, low_clamped, clamped;
    logic signed [15:0] target;

    // Step size signals
    logic        [15:0] accel_mag, decel_mag;
    logic        [16:0] dt_sat;
    logic        [32:0] accel_full, decel_full, up_sum, down_sum;
    logic        [15:0] step_up, step_down;

    // Slew signals
    logic signed [15:0] current;
    logic signed [16:0] delta;
    logic        [16:0] delta_mag;
    logic               delta_pos;
    logic        [15:0] step;
    logic signed [15:0] result;
    logic signed [16:0] result_ext, out_ext;
    logic        [16:0] result_mag, out_mag;
    logic               quiet_ok;

    // Handshake
    assign s1_go     = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_go;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign velocity  = out_velocity_reg;
    assign publish   = out_publish_reg;

    always_comb
    begin
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        out_valid_next = s1_go ? s1_valid_reg : out_valid_reg;
    end

    // Configuration registers
    always_comb
    begin
        deadband_next     = deadband_reg;
        gain_next         = gain_reg;
        boost_floor_next  = boost_floor_reg;
        vel_low_next      = vel_low_reg;
        vel_high_next     = vel_high_reg;
        accel_limit_next  = accel_limit_reg;
        decel_limit_next  = decel_limit_reg;
        idle_epsilon_next = idle_epsilon_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (vel_slew_pkg::cfg_index_t'(cfg_index))
                vel_slew_pkg::CFG_DEADBAND:     deadband_next     = cfg_data;
                vel_slew_pkg::CFG_GAIN:         gain_next         = cfg_data;
                vel_slew_pkg::CFG_BOOST_FLOOR:  boost_floor_next  = cfg_data[14:0];
                vel_slew_pkg::CFG_VEL_LOW:      vel_low_next      = cfg_data;
                vel_slew_pkg::CFG_VEL_HIGH:     vel_high_next     = cfg_data;
                vel_slew_pkg::CFG_ACCEL_LIMIT:  accel_limit_next  = cfg_data;
                vel_slew_pkg::CFG_DECEL_LIMIT:  decel_limit_next  = cfg_data;
                vel_slew_pkg::CFG_IDLE_EPSILON: idle_epsilon_next = cfg_data[14:0];
            endcase
        end
    end

    // Input register
    always_comb
    begin
        s1_next = s1_reg;
        if (in_valid && in_ready)
        begin
            s1_next.command           = command;
            s1_next.mode              = vel_slew_pkg::mode_t'(mode);
            s1_next.feedback_valid    = feedback_valid;
            s1_next.feedback_velocity = feedback_velocity;
            s1_next.tick_dt           = tick_dt;
        end
    end

    // Shaping: deadband, boost product, rounding, minimum boost and clamping
    always_comb
    begin
        cmd_ext     = {s1_reg.command[15], s1_reg.command};
        db_ext      = {deadband_reg[15], deadband_reg};
        cmd_mag     = cmd_ext[16] ? 17'(-cmd_ext) : 17'(cmd_ext);
        db_mag      = db_ext[16] ? 17'(-db_ext) : 17'(db_ext);
        in_deadband = cmd_mag < db_mag;
        filt_mag    = in_deadband ? 17'd0 : cmd_mag;
        filtered    = in_deadband ? 16'sd0 : s1_reg.command;
        boost_neg   = !in_deadband && s1_reg.command[15] && (gain_reg != 16'd0);

        boost_full   = {16'd0, filt_mag} * {17'd0, gain_reg};
        boost_sum    = boost_full + vel_slew_pkg::BOOST_ROUND;
        boost_round  = boost_sum[31:12];
        boost_lifted = ((boost_floor_reg != 15'd0) && (boost_round < {5'd0, boost_floor_reg}))
                       ? {5'd0, boost_floor_reg} : boost_round;
        if (boost_neg)
        begin
            boost_value = (boost_lifted > vel_slew_pkg::NEG_LIMIT) ? 16'sh8000
                          : $signed(~boost_lifted[15:0] + 16'd1);
        end
        else
        begin
            boost_value = (boost_lifted > vel_slew_pkg::POS_LIMIT) ? 16'sd32767
                          : $signed(boost_lifted[15:0]);
        end

        pre_clamp   = (s1_reg.mode == vel_slew_pkg::MODE_PASSTHROUGH) ? filtered
                                                                       : boost_value;
        low_clamped = (pre_clamp < vel_low_reg) ? vel_low_reg : pre_clamp;
        clamped     = (low_clamped > vel_high_reg) ? vel_high_reg : low_clamped;

        target = ((s1_reg.mode == vel_slew_pkg::MODE_PASSTHROUGH)
                  || ((s1_reg.mode == vel_slew_pkg::MODE_BOOST) && (filt_mag != 17'd0)))
                 ? clamped : 16'sd0;
    end

    // Step sizes for rising and falling velocity
    always_comb
    begin
        accel_mag  = accel_limit_reg[15] ? (~accel_limit_reg + 16'd1) : accel_limit_reg;
        decel_mag  = decel_limit_reg[15] ? (~decel_limit_reg + 16'd1) : decel_limit_reg;
        dt_sat     = (s1_reg.tick_dt > vel_slew_pkg::DT_ONE) ? vel_slew_pkg::DT_ONE
                                                              : s1_reg.tick_dt;
        accel_full = {17'd0, accel_mag} * {16'd0, dt_sat};
        decel_full = {17'd0, decel_mag} * {16'd0, dt_sat};
        up_sum     = accel_full + vel_slew_pkg::STEP_ROUND;
        down_sum   = decel_full + vel_slew_pkg::STEP_ROUND;
        step_up    = up_sum[31:16];
        step_down  = down_sum[31:16];
    end

    // Slew: step from the current velocity toward the target
    always_comb
    begin
        current    = s1_reg.feedback_valid ? s1_reg.feedback_velocity : last_output_reg;
        delta      = {target[15], target} - {current[15], current};
        delta_pos  = !delta[16] && (delta != 17'sd0);
        delta_mag  = delta[16] ? 17'(-delta) : 17'(delta);
        step       = delta_pos ? step_up : step_down;
        if (delta_mag <= {1'b0, step})
        begin
            result = target;
        end
        else if (delta_pos)
        begin
            result = $signed(current + step);
        end
        else
        begin
            result = $signed(current - step);
        end
        result_ext = {result[15], result};
        result_mag = result_ext[16] ? 17'(-result_ext) : 17'(result_ext);

        last_output_next  = last_output_reg;
        out_velocity_next = out_velocity_reg;
        out_publish_next  = out_publish_reg;
        if (s1_valid_reg && s1_go)
        begin
            last_output_next  = result;
            out_velocity_next = result;
            out_publish_next  = !((s1_reg.mode == vel_slew_pkg::MODE_NO_SOURCE)
                                  && (result_mag <= {2'd0, idle_epsilon_reg}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg     <= vel_slew_pkg::DEADBAND_RESET;
            gain_reg         <= vel_slew_pkg::GAIN_RESET;
            boost_floor_reg  <= vel_slew_pkg::BOOST_FLOOR_RESET;
            vel_low_reg      <= vel_slew_pkg::VEL_LOW_RESET;
            vel_high_reg     <= vel_slew_pkg::VEL_HIGH_RESET;
            accel_limit_reg  <= vel_slew_pkg::ACCEL_LIMIT_RESET;
            decel_limit_reg  <= vel_slew_pkg::DECEL_LIMIT_RESET;
            idle_epsilon_reg <= vel_slew_pkg::IDLE_EPSILON_RESET;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_output_reg  <= 16'sd0;
        end
        else
        begin
            deadband_reg     <= deadband_next;
            gain_reg         <= gain_next;
            boost_floor_reg  <= boost_floor_next;
            vel_low_reg      <= vel_low_next;
            vel_high_reg     <= vel_high_next;
            accel_limit_reg  <= accel_limit_next;
            decel_limit_reg  <= decel_limit_next;
            idle_epsilon_reg <= idle_epsilon_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            last_output_reg  <= last_output_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg           <= s1_next;
        out_velocity_reg <= out_velocity_next;
        out_publish_reg  <= out_publish_next;
    end

    assign out_ext  = {out_velocity_reg[15], out_velocity_reg};
    assign out_mag  = out_ext[16] ? 17'(-out_ext) : 17'(out_ext);
    assign quiet_ok = out_mag <= {2'd0, idle_epsilon_reg};

`include "velocity_shape_and_slew_axis_unit_assert.svh"

    `VSS_ASSERT_NEXT(a_last_output_tracks, s1_valid_reg && s1_go, last_output_reg == velocity)
    `VSS_ASSERT_HOLDS(a_blocked_only_when_full, !in_ready, s1_valid_reg && out_valid_reg && !out_ready)
    `VSS_ASSERT_HOLDS(a_quiet_result_is_small, out_valid_reg && !out_publish_reg, quiet_ok)

endmodule

`default_nettype wire

// ===== sim/axis_velocity_check.sv =====
`timescale 1ns / 1ps

module axis_velocity_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] command,
    input  logic        [1:0]  mode,
    input  logic               feedback_valid,
    input  logic signed [15:0] feedback_velocity,
    input  logic        [16:0] tick_dt,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] velocity,
    input  logic               publish,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [15:0] cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] velocity;
        logic               publish;
    } axis_result_t;

    axis_result_t expected_q[$];

    int deadband_v;
    int gain_v;
    int boost_floor_v;
    int min_vel_v;
    int max_vel_v;
    int accel_v;
    int decel_v;
    int idle_eps_v;
    int last_vel;

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_velocity(int v);
        int r;
        r = v;
        if (r < min_vel_v)
            r = min_vel_v;
        if (r > max_vel_v)
            r = max_vel_v;
        return r;
    endfunction

    function automatic int shaped_target(int cmd, logic [1:0] md);
        int     filt;
        longint prod;
        longint mag_rounded;
        bit     neg;
        int     v;
        filt = (magnitude(cmd) < magnitude(deadband_v)) ? 0 : cmd;
        if (md == vel_slew_pkg::MODE_PASSTHROUGH)
            return clamp_velocity(filt);
        if (md != vel_slew_pkg::MODE_BOOST || filt == 0)
            return 0;
        prod = longint'(filt) * longint'(gain_v);
        neg = (prod < 0);
        mag_rounded = ((neg ? -prod : prod) + 2048) >> 12;
        if (boost_floor_v > 0 && mag_rounded < longint'(boost_floor_v))
            mag_rounded = boost_floor_v;
        if (neg)
            v = (mag_rounded > 32768) ? -32768 : -int'(mag_rounded);
        else
            v = (mag_rounded > 32767) ? 32767 : int'(mag_rounded);
        return clamp_velocity(v);
    endfunction

    function automatic int slewed_velocity(int target, int current, int dt);
        int delta;
        int lim;
        int stride;
        if (dt > int'(vel_slew_pkg::DT_ONE))
            dt = int'(vel_slew_pkg::DT_ONE);
        if (dt == 0)
            return current;
        delta = target - current;
        if (delta == 0)
            return target;
        lim = (delta > 0) ? magnitude(accel_v) : magnitude(decel_v);
        stride = int'((longint'(lim) * longint'(dt) + 32768) >> 16);
        if (magnitude(delta) <= stride)
            return target;
        return (delta > 0) ? current + stride : current - stride;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        axis_result_t want;
        int           target;
        int           current;
        int           outcome;
        if (!rst_n)
        begin
            deadband_v    = vel_slew_pkg::DEADBAND_RESET;
            gain_v        = vel_slew_pkg::GAIN_RESET;
            boost_floor_v = vel_slew_pkg::BOOST_FLOOR_RESET;
            min_vel_v     = vel_slew_pkg::VEL_LOW_RESET;
            max_vel_v     = vel_slew_pkg::VEL_HIGH_RESET;
            accel_v       = vel_slew_pkg::ACCEL_LIMIT_RESET;
            decel_v       = vel_slew_pkg::DECEL_LIMIT_RESET;
            idle_eps_v    = vel_slew_pkg::IDLE_EPSILON_RESET;
            last_vel      = 0;
            errors        = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $error("velocity result with no request outstanding: got %0d", velocity);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (velocity !== want.velocity)
                    begin
                        errors++;
                        $error("velocity mismatch: expected %0d, got %0d",
                               want.velocity, velocity);
                    end
                    if (publish !== want.publish)
                    begin
                        errors++;
                        $error("publish mismatch: expected %0d, got %0d",
                               want.publish, publish);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (vel_slew_pkg::cfg_index_t'(cfg_index))
                    vel_slew_pkg::CFG_DEADBAND:     deadband_v    = $signed(cfg_data);
                    vel_slew_pkg::CFG_GAIN:         gain_v        = cfg_data;
                    vel_slew_pkg::CFG_BOOST_FLOOR:  boost_floor_v = cfg_data[14:0];
                    vel_slew_pkg::CFG_VEL_LOW:      min_vel_v     = $signed(cfg_data);
                    vel_slew_pkg::CFG_VEL_HIGH:     max_vel_v     = $signed(cfg_data);
                    vel_slew_pkg::CFG_ACCEL_LIMIT:  accel_v       = $signed(cfg_data);
                    vel_slew_pkg::CFG_DECEL_LIMIT:  decel_v       = $signed(cfg_data);
                    vel_slew_pkg::CFG_IDLE_EPSILON: idle_eps_v    = cfg_data[14:0];
                    default:                        ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                target  = shaped_target(command, mode);
                current = feedback_valid ? int'(feedback_velocity) : last_vel;
                outcome = slewed_velocity(target, current, tick_dt);
                last_vel = outcome;
                want.velocity = outcome[15:0];
                want.publish  = !(mode == vel_slew_pkg::MODE_NO_SOURCE
                                  && magnitude(outcome) <= idle_eps_v);
                expected_q.insert(expected_q.size(), want);
            end

            pending <= expected_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [15:0] deadband;
        logic [15:0] gain;
        logic [15:0] boost_floor;
        logic [15:0] vel_low;
        logic [15:0] vel_high;
        logic [15:0] accel_limit;
        logic [15:0] decel_limit;
        logic [15:0] idle_epsilon;
    } axis_cfg_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [15:0]       command = '0;
    vel_slew_pkg::mode_t      mode = vel_slew_pkg::MODE_PASSTHROUGH;
    logic                     feedback_valid = 1'b0;
    logic signed [15:0]       feedback_velocity = '0;
    logic        [16:0]       tick_dt = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [15:0]       velocity;
    logic                     publish;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    vel_slew_pkg::cfg_index_t cfg_index = vel_slew_pkg::CFG_DEADBAND;
    logic        [15:0]       cfg_data = '0;

    int errors;
    int pending;
    int send_idle = 10;
    int recv_idle = 64;

    velocity_shape_and_slew_axis_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .mode              (mode),
        .feedback_valid    (feedback_valid),
        .feedback_velocity (feedback_velocity),
        .tick_dt           (tick_dt),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .velocity          (velocity),
        .publish           (publish),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    axis_velocity_check i_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .mode              (mode),
        .feedback_valid    (feedback_valid),
        .feedback_velocity (feedback_velocity),
        .tick_dt           (tick_dt),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .velocity          (velocity),
        .publish           (publish),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .errors            (errors),
        .pending           (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [15:0] around_zero(int span);
        int v;
        v = $urandom_range(2 * span);
        return 16'(v - span);
    endfunction

    function automatic axis_cfg_t random_setting();
        axis_cfg_t s;
        s.deadband  = ($urandom_range(3) == 0) ? 16'($urandom) : around_zero(1500);
        s.gain      = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048, 8192));
        case ($urandom_range(3))
            0:       s.boost_floor = '0;
            1:       s.boost_floor = 16'($urandom_range(32767));
            default: s.boost_floor = 16'($urandom_range(2048));
        endcase
        if ($urandom_range(7) == 0)
        begin
            s.vel_low  = 16'($urandom);
            s.vel_high = 16'($urandom);
        end
        else
        begin
            s.vel_low  = 16'(-$urandom_range(12000));
            s.vel_high = 16'($urandom_range(12000));
        end
        s.accel_limit  = ($urandom_range(3) == 0) ? 16'($urandom) : around_zero(20000);
        s.decel_limit  = ($urandom_range(3) == 0) ? 16'($urandom) : around_zero(20000);
        s.idle_epsilon = ($urandom_range(7) == 0) ? 16'($urandom_range(32767))
                                                  : 16'($urandom_range(64));
        return s;
    endfunction

    task automatic write_reg(vel_slew_pkg::cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(axis_cfg_t s);
        write_reg(vel_slew_pkg::CFG_DEADBAND, s.deadband);
        write_reg(vel_slew_pkg::CFG_GAIN, s.gain);
        write_reg(vel_slew_pkg::CFG_BOOST_FLOOR, s.boost_floor);
        write_reg(vel_slew_pkg::CFG_VEL_LOW, s.vel_low);
        write_reg(vel_slew_pkg::CFG_VEL_HIGH, s.vel_high);
        write_reg(vel_slew_pkg::CFG_ACCEL_LIMIT, s.accel_limit);
        write_reg(vel_slew_pkg::CFG_DECEL_LIMIT, s.decel_limit);
        write_reg(vel_slew_pkg::CFG_IDLE_EPSILON, s.idle_epsilon);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic signed [15:0] cmd, vel_slew_pkg::mode_t md,
                                logic fb_ok, logic signed [15:0] fb, logic [16:0] dt);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid          <= 1'b1;
        command           <= cmd;
        mode              <= md;
        feedback_valid    <= fb_ok;
        feedback_velocity <= fb;
        tick_dt           <= dt;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_request();
        logic signed [15:0] cmd;
        logic        [16:0] dt;
        case ($urandom_range(3))
            0:       cmd = 16'($urandom);
            3:       cmd = around_zero(300);
            default: cmd = around_zero(8000);
        endcase
        case ($urandom_range(7))
            0:       dt = '0;
            1:       dt = 17'($urandom_range(65537, 131071));
            2:       dt = vel_slew_pkg::DT_ONE;
            default: dt = 17'($urandom_range(1, 20000));
        endcase
        send_request(cmd, vel_slew_pkg::mode_t'($urandom_range(3)), ($urandom_range(3) == 0),
                     16'($urandom), dt);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin : stimulus
        axis_cfg_t s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(16'sd32767, vel_slew_pkg::MODE_PASSTHROUGH, 1'b0, 16'sd0,
                     vel_slew_pkg::DT_ONE);
        send_request(-16'sd32768, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd32767, 17'h1FFFF);
        send_request(16'sd0, vel_slew_pkg::MODE_BOOST, 1'b1, -16'sd32768, 17'd1);
        send_request(16'sd1000, vel_slew_pkg::MODE_STOP, 1'b0, 16'sd0, 17'd0);
        send_request(16'sd3, vel_slew_pkg::MODE_NO_SOURCE, 1'b1, 16'sd3, 17'd0);
        send_request(-16'sd200, vel_slew_pkg::MODE_NO_SOURCE, 1'b0, 16'sd0,
                     vel_slew_pkg::DT_ONE);
        settle();

        s.deadband     = 16'h8000;
        s.gain         = 16'hFFFF;
        s.boost_floor  = 16'h7FFF;
        s.vel_low      = 16'h7FFF;
        s.vel_high     = 16'h8000;
        s.accel_limit  = 16'h8000;
        s.decel_limit  = 16'h7FFF;
        s.idle_epsilon = 16'h7FFF;
        apply_setting(s);
        send_request(16'sd0, vel_slew_pkg::MODE_PASSTHROUGH, 1'b0, 16'sd0,
                     vel_slew_pkg::DT_ONE);
        send_request(-16'sd32768, vel_slew_pkg::MODE_BOOST, 1'b0, 16'sd0,
                     vel_slew_pkg::DT_ONE);
        send_request(16'sd32767, vel_slew_pkg::MODE_BOOST, 1'b1, -16'sd32768,
                     vel_slew_pkg::DT_ONE);
        send_request(-16'sd1, vel_slew_pkg::MODE_NO_SOURCE, 1'b1, 16'sd32767, 17'h10001);
        send_request(16'sd32767, vel_slew_pkg::MODE_PASSTHROUGH, 1'b1, 16'sd32767, 17'd1);
        settle();

        s.deadband     = 16'd100;
        s.gain         = 16'd2048;
        s.boost_floor  = 16'd0;
        s.vel_low      = 16'h8000;
        s.vel_high     = 16'h7FFF;
        s.accel_limit  = 16'd4096;
        s.decel_limit  = 16'(-4096);
        s.idle_epsilon = 16'd0;
        apply_setting(s);
        send_request(16'sd100, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd0, vel_slew_pkg::DT_ONE);
        send_request(-16'sd99, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd0, vel_slew_pkg::DT_ONE);
        send_request(16'sd101, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd0, vel_slew_pkg::DT_ONE);
        send_request(-16'sd101, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd0, vel_slew_pkg::DT_ONE);
        send_request(16'sd20, vel_slew_pkg::MODE_NO_SOURCE, 1'b1, 16'sd0,
                     vel_slew_pkg::DT_ONE);
        send_request(16'sd5000, vel_slew_pkg::MODE_PASSTHROUGH, 1'b1, 16'sd0, 17'd8);
        send_request(16'sd5000, vel_slew_pkg::MODE_PASSTHROUGH, 1'b1, 16'sd0, 17'd7);
        send_request(-16'sd5000, vel_slew_pkg::MODE_PASSTHROUGH, 1'b0, 16'sd0, 17'd24);
        settle();

        s.deadband     = 16'd0;
        s.gain         = 16'd0;
        s.boost_floor  = 16'd1000;
        s.accel_limit  = 16'h7FFF;
        s.decel_limit  = 16'h8000;
        s.idle_epsilon = 16'd10;
        apply_setting(s);
        send_request(-16'sd7, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd0, vel_slew_pkg::DT_ONE);
        settle();
        write_reg(vel_slew_pkg::CFG_GAIN, 16'd1);
        cfg_valid <= 1'b0;
        send_request(-16'sd5, vel_slew_pkg::MODE_BOOST, 1'b1, 16'sd0, vel_slew_pkg::DT_ONE);
        send_request(16'sd5, vel_slew_pkg::MODE_BOOST, 1'b0, 16'sd0, vel_slew_pkg::DT_ONE);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle = 10;
                    recv_idle = 64;
                end
                1:
                begin
                    send_idle = 64;
                    recv_idle = 10;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            apply_setting(random_setting());
            repeat (240) send_random_request();
            settle();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vel_slew_pkg.sv
rtl/core/velocity_shape_and_slew_axis_unit.sv
sim/axis_velocity_check.sv
sim/tb.sv
